FILE: hw/rtl/kalman_angle_bias_filter_macros.svh
// Assertion macros for the angle/bias filter RTL.
// Expects a clock named clk and an active-low reset named arst_n in the calling scope.
`ifndef KALMAN_ANGLE_BIAS_FILTER_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define KAB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define KAB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/kab_pkg.sv
// Shared types and constants for the angle/bias Kalman filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package kab_pkg;

	// Field and datapath widths
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned NOISE_W   = 31;
	localparam int unsigned DT_W      = 17;
	localparam int unsigned OPND_W    = 33;
	localparam int unsigned PROD_W    = 66;
	localparam int unsigned ACC_W     = 68;
	localparam int unsigned DELTA_W   = 42;
	localparam int unsigned SUM_W     = 43;
	localparam int unsigned REG_IDX_W = 2;

	// Product shifts: Q16.16 results and Q8.24 results
	localparam int unsigned SH_RATE = 16;
	localparam int unsigned SH_GAIN = 24;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_Q_ANGLE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_Q_BIAS  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_R_MEAS  = 2'd2;

	// Register reset values
	localparam logic [NOISE_W-1:0] Q_ANGLE_RST = 31'd16777;
	localparam logic [NOISE_W-1:0] Q_BIAS_RST  = 31'd50332;
	localparam logic [NOISE_W-1:0] R_MEAS_RST  = 31'd503316;

	// One second in unsigned Q1.16
	localparam logic [DT_W-1:0] DT_MAX = 17'd65536;

	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [WORD_W-1:0] measured_angle;
		logic signed [WORD_W-1:0] gyro_rate;
		logic [DT_W-1:0]          time_step;
	} kab_in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] filtered_angle;
		logic signed [WORD_W-1:0] rate_bias;
	} kab_out_t;

	// Multiply-accumulate command
	typedef struct packed {
		logic valid;   // a term is issued this cycle
		logic clr;     // restart the sum from the rounding constant
		logic neg;     // subtract the product
		logic rnd24;   // round for a 24-bit shift instead of 16
	} kab_mac_op_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} kab_div_state_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ANG,
		ST_T,
		ST_ANG_WB,
		ST_T_WB,
		ST_INNER2,
		ST_INNER3,
		ST_Q11,
		ST_C00_WB,
		ST_C11_WB,
		ST_DIV0,
		ST_DIV0_WAIT,
		ST_DIV1,
		ST_DIV1_WAIT,
		ST_K0_INNOV,
		ST_K1_INNOV,
		ST_ANG_CORR,
		ST_BIAS_CORR,
		ST_C10_CORR,
		ST_C11_CORR,
		ST_C00_CORR,
		ST_C01_CORR,
		ST_DONE
	} kab_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kab_mac.sv
// Shared multiply-accumulate unit: registered 33x33 product, then a rounding accumulator.
// Depends on kab_pkg.
`default_nettype none

module kab_mac import kab_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire kab_mac_op_t              op,
	input  wire logic signed [OPND_W-1:0] a,
	input  wire logic signed [OPND_W-1:0] b,
	output logic signed [ACC_W-1:0]       acc
);

	localparam logic signed [ACC_W-1:0] RND_RATE = ACC_W'(1) << (SH_RATE - 1);
	localparam logic signed [ACC_W-1:0] RND_GAIN = ACC_W'(1) << (SH_GAIN - 1);

	kab_mac_op_t               op_s1;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   base;
	logic signed [ACC_W-1:0]   prod_x;

	// Stage 1: hold the command and the exact product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	// Stage 2: restart or extend the running sum
	always_comb begin
		base   = op_s1.clr ? (op_s1.rnd24 ? RND_GAIN : RND_RATE) : acc_q;
		prod_x = ACC_W'(prod_s1);
	end

	always_ff @(posedge clk) begin
		if (op_s1.valid) begin
			acc_q <= op_s1.neg ? (base - prod_x) : (base + prod_x);
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

FILE: hw/rtl/kab_div.sv
// Radix-4 restoring divider for the gains: (numer * 2^24) / denom, saturated to 32 bits.
// Depends on kab_pkg and the assertion macro header.
`default_nettype none
`include "kalman_angle_bias_filter_macros.svh"

module kab_div import kab_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [WORD_W-1:0] numer,
	input  wire logic [WORD_W-1:0]        denom,
	output logic                          done,
	output logic signed [WORD_W-1:0]      quot
);

	localparam int unsigned STEPS  = WORD_W / 2;
	localparam int unsigned CNT_W  = $clog2(STEPS);
	localparam int unsigned OVF_SH = WORD_W - 1 - SH_GAIN;
	localparam int unsigned CMP_W  = WORD_W + OVF_SH + 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

	kab_div_state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] rem_q, low_q, q_q, den_q;
	logic              neg_q, ovf_q;

	logic [WORD_W-1:0] num_u, mag;
	logic [CMP_W-1:0]  mag_x, lim_x;
	logic              ovf;
	logic [WORD_W:0]   r1, r1s, r2, r2s;
	logic              b1, b2;

	// Magnitude and early overflow check: quotient >= 2^31 iff mag >= denom * 2^7
	always_comb begin
		num_u = numer;
		mag   = num_u[WORD_W-1] ? (~num_u + 1'b1) : num_u;
		mag_x = CMP_W'(mag);
		lim_x = CMP_W'(denom) << OVF_SH;
		ovf   = (mag_x >= lim_x);
	end

	// Two quotient bits per cycle
	always_comb begin
		r1  = {rem_q, low_q[WORD_W-1]};
		b1  = (r1 >= {1'b0, den_q});
		r1s = b1 ? (r1 - {1'b0, den_q}) : r1;
		r2  = {r1s[WORD_W-1:0], low_q[WORD_W-2]};
		b2  = (r2 >= {1'b0, den_q});
		r2s = b2 ? (r2 - {1'b0, den_q}) : r2;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (start) begin
					state_d = ovf ? DIV_DONE : DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (cnt_q == CNT_LAST) begin
					state_d = DIV_DONE;
				end
			end
			DIV_DONE: state_d = DIV_IDLE;
			default:  state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == DIV_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// Load the operands on start, then shift the remainder and quotient
	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			rem_q <= mag >> (WORD_W - SH_GAIN);
			low_q <= mag << SH_GAIN;
			q_q   <= '0;
			den_q <= denom;
			neg_q <= num_u[WORD_W-1];
			ovf_q <= ovf;
		end else if (state_q == DIV_RUN) begin
			rem_q <= r2s[WORD_W-1:0];
			low_q <= low_q << 2;
			q_q   <= {q_q[WORD_W-3:0], b1, b2};
		end
	end

	// Outputs: restore the sign or saturate
	always_comb begin
		done = (state_q == DIV_DONE);
		if (ovf_q) begin
			quot = neg_q ? WORD_MIN : WORD_MAX;
		end else begin
			quot = neg_q ? (~q_q + 1'b1) : q_q;
		end
	end

	`KAB_ASSERT_IMP(a_start_when_idle, start, state_q == DIV_IDLE, "divider started while busy")
	`KAB_ASSERT_IMP(a_rem_below_den, state_q == DIV_RUN, rem_q < den_q, "remainder not below divisor")
	`KAB_ASSERT_IMP(a_quot_fits, (state_q == DIV_DONE) && !ovf_q, !q_q[WORD_W-1], "quotient overflow missed")

endmodule

`default_nettype wire

FILE: hw/rtl/kalman_angle_bias_filter.sv
// The sequence is shorter when one or both gains saturate early, and shortest when
// cov_00 + measurement_noise is not positive, since both gain divisions are then skipped.
// A new word is accepted only in idle, once the last is in the output register; the pace is set
// by the two 16-step radix-4 gain divisions and the single shared multiply-accumulate unit.
// Reset (arst_n, asynchronous): estimates and covariance clear to zero, noise registers
// return to their defaults, no output word pending.
`default_nettype none
`include "kalman_angle_bias_filter_macros.svh"

module kalman_angle_bias_filter import kab_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [REG_IDX_W-1:0] wr_index,
	input  wire logic [NOISE_W-1:0]   wr_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire kab_in_t              in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output kab_out_t                  out_data
);

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-WORD_W:0] hi_bits;
		hi_bits = v[SUM_W-1:WORD_W-1];
		if (hi_bits == '0 || hi_bits == '1) begin
			return v[WORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			return WORD_MIN;
		end else begin
			return WORD_MAX;
		end
	endfunction

	kab_state_t state_q, state_d;

	// Noise registers
	logic [NOISE_W-1:0] pna_q, pnb_q, mn_q;

	// Filter state
	logic signed [WORD_W-1:0] ang_q, bias_q, c00_q, c01_q, c10_q, c11_q;

	// Per-word working values
	logic [DT_W-1:0]          dt_q;
	logic signed [WORD_W-1:0] meas_q, rate_q, innov_q, k0_q, k1_q;
	logic signed [OPND_W-1:0] t_q;

	// Output register
	logic     out_valid_q;
	kab_out_t out_data_q;

	// Shared unit connections
	kab_mac_op_t              mac_op;
	logic signed [OPND_W-1:0] mac_a, mac_b;
	logic signed [ACC_W-1:0]  acc, acc_sh16, acc_sh24;
	logic signed [DELTA_W-1:0] d16, d24;

	logic                     div_start, div_done;
	logic signed [WORD_W-1:0] div_numer, div_quot;

	logic signed [WORD_W:0] denom_s;
	logic                   denom_pos;
	logic                   out_load;
	logic [DT_W-1:0]        dt_in;

	kab_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc)
	);

	kab_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (denom_s[WORD_W-1:0]),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Rounded, shifted sums from the accumulator
	assign acc_sh16 = acc >>> SH_RATE;
	assign acc_sh24 = acc >>> SH_GAIN;
	assign d16      = acc_sh16[DELTA_W-1:0];
	assign d24      = acc_sh24[DELTA_W-1:0];

	// Gain denominator and clamped time step
	always_comb begin
		denom_s   = (WORD_W + 1)'(c00_q) + (WORD_W + 1)'(mn_q);
		denom_pos = !denom_s[WORD_W] && (denom_s != '0);
		dt_in     = (in_data.time_step > DT_MAX) ? DT_MAX : in_data.time_step;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_ANG;
				end
			end
			ST_ANG:       state_d = ST_T;
			ST_T:         state_d = ST_ANG_WB;
			ST_ANG_WB:    state_d = ST_T_WB;
			ST_T_WB:      state_d = ST_INNER2;
			ST_INNER2:    state_d = ST_INNER3;
			ST_INNER3:    state_d = ST_Q11;
			ST_Q11:       state_d = ST_C00_WB;
			ST_C00_WB:    state_d = ST_C11_WB;
			ST_C11_WB:    state_d = ST_DIV0;
			ST_DIV0:      state_d = denom_pos ? ST_DIV0_WAIT : ST_K0_INNOV;
			ST_DIV0_WAIT: begin
				if (div_done) begin
					state_d = ST_DIV1;
				end
			end
			ST_DIV1:      state_d = ST_DIV1_WAIT;
			ST_DIV1_WAIT: begin
				if (div_done) begin
					state_d = ST_K0_INNOV;
				end
			end
			ST_K0_INNOV:  state_d = ST_K1_INNOV;
			ST_K1_INNOV:  state_d = ST_ANG_CORR;
			ST_ANG_CORR:  state_d = ST_BIAS_CORR;
			ST_BIAS_CORR: state_d = ST_C10_CORR;
			ST_C10_CORR:  state_d = ST_C11_CORR;
			ST_C11_CORR:  state_d = ST_C00_CORR;
			ST_C00_CORR:  state_d = ST_C01_CORR;
			ST_C01_CORR:  state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: at most one multiply term per cycle, divider starts, output load
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		mac_op    = '0;
		mac_a     = OPND_W'(dt_q);
		mac_b     = '0;
		div_start = 1'b0;
		div_numer = c00_q;
		out_load  = 1'b0;
		case (state_q)
			ST_ANG: begin
				mac_op = '{valid: 1'b1, clr: 1'b1, neg: 1'b0, rnd24: 1'b0};
				mac_b  = OPND_W'(rate_q);
			end
			ST_T: begin
				mac_op = '{valid: 1'b1, clr: 1'b1, neg: 1'b0, rnd24: 1'b0};
				mac_b  = OPND_W'(c11_q);
			end
			ST_ANG_WB: begin
				mac_op = '{valid: 1'b1, clr: 1'b1, neg: 1'b1, rnd24: 1'b0};
				mac_b  = OPND_W'(c01_q);
			end
			ST_T_WB: begin
				mac_op = '{valid: 1'b1, clr: 1'b0, neg: 1'b1, rnd24: 1'b0};
				mac_b  = OPND_W'(c10_q);
			end
			ST_INNER2: begin
				mac_op = '{valid: 1'b1, clr: 1'b0, neg: 1'b0, rnd24: 1'b0};
				mac_b  = OPND_W'(pna_q);
			end
			ST_INNER3: begin
				mac_op = '{valid: 1'b1, clr: 1'b0, neg: 1'b0, rnd24: 1'b0};
				mac_b  = t_q;
			end
			ST_Q11: begin
				mac_op = '{valid: 1'b1, clr: 1'b1, neg: 1'b0, rnd24: 1'b0};
				mac_b  = OPND_W'(pnb_q);
			end
			ST_DIV0: begin
				div_start = denom_pos;
				div_numer = c00_q;
			end
			ST_DIV1: begin
				div_start = 1'b1;
				div_numer = c10_q;
			end
			ST_K0_INNOV: begin
				mac_op = '{valid: 1'b1, clr: 1'b1, neg: 1'b0, rnd24: 1'b1};
				mac_a  = OPND_W'(k0_q);
				mac_b  = OPND_W'(innov_q);
			end
			ST_K1_INNOV: begin
				mac_op = '{valid: 1'b1, clr: 1'b1, neg: 1'b0, rnd24: 1'b1};
				mac_a  = OPND_W'(k1_q);
				mac_b  = OPND_W'(innov_q);
			end
			ST_ANG_CORR: begin
				mac_op = '{valid: 1'b1, clr: 1'b1, neg: 1'b0, rnd24: 1'b1};
				mac_a  = OPND_W'(k1_q);
				mac_b  = OPND_W'(c00_q);
			end
			ST_BIAS_CORR: begin
				mac_op = '{valid: 1'b1, clr: 1'b1, neg: 1'b0, rnd24: 1'b1};
				mac_a  = OPND_W'(k1_q);
				mac_b  = OPND_W'(c01_q);
			end
			ST_C10_CORR: begin
				mac_op = '{valid: 1'b1, clr: 1'b1, neg: 1'b0, rnd24: 1'b1};
				mac_a  = OPND_W'(k0_q);
				mac_b  = OPND_W'(c00_q);
			end
			ST_C11_CORR: begin
				mac_op = '{valid: 1'b1, clr: 1'b1, neg: 1'b0, rnd24: 1'b1};
				mac_a  = OPND_W'(k0_q);
				mac_b  = OPND_W'(c01_q);
			end
			ST_DONE: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Noise registers; a zero measurement noise is stored as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pna_q <= Q_ANGLE_RST;
			pnb_q <= Q_BIAS_RST;
			mn_q  <= R_MEAS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_Q_ANGLE: pna_q <= wr_data;
				REG_Q_BIAS:  pnb_q <= wr_data;
				REG_R_MEAS:  mn_q  <= (wr_data == '0) ? NOISE_W'(1) : wr_data;
				default: begin
				end
			endcase
		end
	end

	// Write back predicted and corrected state from the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q  <= '0;
			bias_q <= '0;
			c00_q  <= '0;
			c01_q  <= '0;
			c10_q  <= '0;
			c11_q  <= '0;
		end else begin
			case (state_q)
				ST_ANG_WB:    ang_q <= sat_word(SUM_W'(ang_q) + SUM_W'(d16));
				ST_C00_WB: begin
					c00_q <= sat_word(SUM_W'(c00_q) + SUM_W'(d16));
					c01_q <= sat_word(SUM_W'(c01_q) - SUM_W'(t_q));
					c10_q <= sat_word(SUM_W'(c10_q) - SUM_W'(t_q));
				end
				ST_C11_WB:    c11_q  <= sat_word(SUM_W'(c11_q) + SUM_W'(d16));
				ST_ANG_CORR:  ang_q  <= sat_word(SUM_W'(ang_q) + SUM_W'(d24));
				ST_BIAS_CORR: bias_q <= sat_word(SUM_W'(bias_q) + SUM_W'(d24));
				ST_C10_CORR:  c10_q  <= sat_word(SUM_W'(c10_q) - SUM_W'(d24));
				ST_C11_CORR:  c11_q  <= sat_word(SUM_W'(c11_q) - SUM_W'(d24));
				ST_C00_CORR:  c00_q  <= sat_word(SUM_W'(c00_q) - SUM_W'(d24));
				ST_C01_CORR:  c01_q  <= sat_word(SUM_W'(c01_q) - SUM_W'(d24));
				default: begin
				end
			endcase
		end
	end

	// Capture the input word and the intermediate terms
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					dt_q   <= dt_in;
					meas_q <= in_data.measured_angle;
					rate_q <= sat_word(SUM_W'(in_data.gyro_rate) - SUM_W'(bias_q));
				end
			end
			ST_T_WB: t_q <= acc_sh16[OPND_W-1:0];
			ST_DIV0: begin
				innov_q <= sat_word(SUM_W'(meas_q) - SUM_W'(ang_q));
				if (!denom_pos) begin
					k0_q <= '0;
					k1_q <= '0;
				end
			end
			ST_DIV0_WAIT: begin
				if (div_done) begin
					k0_q <= div_quot;
				end
			end
			ST_DIV1_WAIT: begin
				if (div_done) begin
					k1_q <= div_quot;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.filtered_angle <= ang_q;
			out_data_q.rate_bias      <= bias_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`KAB_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == ST_ANG, "accepted word did not start the sequence")
	`KAB_ASSERT_IMP(a_div_done_waited, div_done, state_q == ST_DIV0_WAIT || state_q == ST_DIV1_WAIT, "gain ready outside a wait state")
	`KAB_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "output word raised outside completion")

endmodule

`default_nettype wire
